>>> hdl/lrce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting remote command encoder package
// Command codes, register indexes and packet constants for the encoder core.
// ----------------------------------------------------------------------------
package lrce_pkg;

  // Kinds of input items.
  typedef enum logic [1:0] {
    CMD_CODE  = 2'd0,
    CMD_IDLE  = 2'd1,
    CMD_ASSOC = 2'd2,
    CMD_RAW   = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_REMOTE_ADDRESS  = 2'd0,
    REG_DEFAULT_RESENDS = 2'd1,
    REG_RESEND_DELAY    = 2'd2,
    REG_SILENT_MODE     = 2'd3
  } reg_e;

  localparam int unsigned CfgDataWidth   = 20;
  localparam int unsigned ThrottleLimitDefault = 10;

  localparam logic [15:0] RemoteAddressReset = 16'h0001;
  localparam logic [7:0]  DefaultResendsReset = 8'd10;

  // Packet constants.
  localparam logic [7:0] Byte0Plain    = 8'hB0;
  localparam logic [7:0] Byte0Button   = 8'hB8;
  localparam logic [7:0] ColorBase     = 8'hC8;
  localparam logic [7:0] BrightBase    = 8'h90;
  localparam logic [7:0] BrightMask    = 8'hF8;
  localparam logic [7:0] LongPressBit  = 8'h10;
  localparam logic [7:0] DiscoOff      = 8'hFF;
  localparam logic [7:0] DiscoLastStep = 8'd8;
  localparam logic [3:0] ThrottleMax   = 4'd15;
  localparam logic [7:0] AssocResends  = 8'd10;
  localparam logic [3:0] AssocPackets  = 4'd11;
  localparam logic [7:0] AssocLongFrom = 8'd4;

  // Command codes.
  localparam logic [7:0] CodeShortFirst = 8'h45;
  localparam logic [7:0] CodeShortLast  = 8'h4C;
  localparam logic [7:0] CodeLongFirst  = 8'hC5;
  localparam logic [7:0] CodeLongLast   = 8'hCC;
  localparam logic [7:0] CodeColor      = 8'h40;
  localparam logic [7:0] CodeAllOn      = 8'h41;
  localparam logic [7:0] CodeAllOff     = 8'h42;
  localparam logic [7:0] CodeLongOn     = 8'hC1;
  localparam logic [7:0] CodeLongOff    = 8'hC2;
  localparam logic [7:0] CodeSpeedUp    = 8'h43;
  localparam logic [7:0] CodeSpeedDown  = 8'h44;
  localparam logic [7:0] CodeDisco      = 8'h4D;
  localparam logic [7:0] CodeBright     = 8'h4E;

  // Button values.
  localparam logic [7:0] BtnColor     = 8'h0F;
  localparam logic [7:0] BtnBright    = 8'h0E;
  localparam logic [7:0] BtnAllOn     = 8'h02;
  localparam logic [7:0] BtnAllOff    = 8'h01;
  localparam logic [7:0] BtnLongOn    = 8'h12;
  localparam logic [7:0] BtnLongOff   = 8'h11;
  localparam logic [7:0] BtnSpeedUp   = 8'h0B;
  localparam logic [7:0] BtnSpeedDown = 8'h0C;
  localparam logic [7:0] BtnDisco     = 8'h0D;
  localparam logic [7:0] BtnRelease   = 8'h00;
  localparam logic [7:0] ButtonOffset = 8'd3;

endpackage

>>> hdl/light_remote_command_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lighting remote command encoder core
// Turns lighting commands into seven-byte radio packets and keeps the remote's
// color, brightness, group, disco step, sequence number and repeat throttle.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Direction
//  input     in_valid_i / in_ready_o, cmd_i ... raw_packet_i  in
//  result    out_valid_o / out_ready_i, packet_bytes_o ...    out
//  config    cfg_we_i, cfg_addr_i, cfg_wdata_i                in, no handshake
//
// An accepted item updates the state in the same cycle and loads its first
// packet into the result register; the packet shows on the next cycle.
// Each further packet of the same item is loaded into the result register as
// the previous one is taken, so an item gives up to 11 packets for an
// association request and up to 3 for an idle tick.
// A new item is taken while the final beat of the previous one is delivered.
// Reset restores state and result valid, not payload; a stalled result holds it.
module light_remote_command_encoder_core #(
  parameter int unsigned THROTTLE_LIMIT = lrce_pkg::ThrottleLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [lrce_pkg::CfgDataWidth-1:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  code_byte_i,
  input  logic [7:0]  arg_byte_i,
  input  logic [7:0]  assoc_addr_hi_i,
  input  logic [7:0]  assoc_addr_lo_i,
  input  logic [7:0]  assoc_group_i,
  input  logic [55:0] raw_packet_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [55:0] packet_bytes_o,
  output logic [7:0]  resend_count_o,
  output logic [19:0] resend_delay_o,
  output logic        last_o
);

  // Configuration registers.
  logic [15:0] remote_address_q;
  logic [7:0]  default_resends_q;
  logic [19:0] resend_delay_q;
  logic        silent_q;

  // Remote state.
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  color_q, color_d;
  logic [7:0]  bright_q, bright_d;
  logic [2:0]  group_q, group_d;
  logic [7:0]  disco_q, disco_d;
  logic [3:0]  thr_q, thr_d;
  logic        color_pend_q, color_pend_d;
  logic        bright_pend_q, bright_pend_d;
  logic [55:0] lp_q, lp_d;

  // Result register and the rest of the current burst.
  logic        out_valid_q, out_valid_d;
  logic [55:0] out_pkt_q, out_pkt_d;
  logic [7:0]  out_rs_q, out_rs_d;
  logic [19:0] out_dl_q, out_dl_d;
  logic        out_last_q, out_last_d;
  logic [3:0]  burst_left_q, burst_left_d;
  logic        burst_assoc_q, burst_assoc_d;
  logic [15:0] spare_q [2];
  logic [15:0] spare_d [2];

  logic        in_fire;
  logic        out_fire;
  logic [7:0]  assoc_n_next;
  logic [15:0] next_tail;

  assign in_ready_o = !out_valid_q || (out_ready_i && (burst_left_q == 4'd0));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Next beat of a burst differs from the current one only in bytes five and six.
  assign assoc_n_next = out_pkt_q[7:0] + 8'd1;
  always_comb begin
    if (burst_assoc_q) begin
      next_tail = {out_pkt_q[15:8] |
                   ((assoc_n_next >= lrce_pkg::AssocLongFrom) ? lrce_pkg::LongPressBit : 8'h00),
                   assoc_n_next};
    end else begin
      next_tail = spare_q[0];
    end
  end

  always_comb begin
    logic [7:0]  button;
    logic        known;
    logic [7:0]  rs;
    logic [2:0]  off;
    logic [7:0]  b0;
    logic [7:0]  disco_inc;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [15:0] e_first;
    logic [15:0] e_second;
    logic [15:0] e_third;
    logic        rel;
    logic [1:0]  n_idle;
    logic [2:0]  agrp;
    logic [7:0]  abtn;

    seq_d         = seq_q;
    color_d       = color_q;
    bright_d      = bright_q;
    group_d       = group_q;
    disco_d       = disco_q;
    thr_d         = thr_q;
    color_pend_d  = color_pend_q;
    bright_pend_d = bright_pend_q;
    lp_d          = lp_q;

    out_valid_d   = out_valid_q;
    out_pkt_d     = out_pkt_q;
    out_rs_d      = out_rs_q;
    out_dl_d      = out_dl_q;
    out_last_d    = out_last_q;
    burst_left_d  = burst_left_q;
    burst_assoc_d = burst_assoc_q;
    spare_d       = spare_q;

    button    = 8'h00;
    known     = 1'b0;
    rs        = default_resends_q;
    off       = 3'(code_byte_i - lrce_pkg::CodeShortFirst);
    b0        = lrce_pkg::Byte0Plain;
    disco_inc = disco_q + 8'd1;
    s1        = seq_q + {7'd0, color_pend_q};
    s2        = s1 + {7'd0, bright_pend_q};
    rel       = color_pend_q || bright_pend_q || (lp_q[15:8] != lrce_pkg::BtnRelease);
    n_idle    = 2'(color_pend_q) + 2'(bright_pend_q) + 2'(rel);
    agrp      = (assoc_group_i > 8'd4) ? 3'd0 : assoc_group_i[2:0];
    abtn      = {4'd0, agrp, 1'b1};

    if (color_pend_q) begin
      e_first = {lrce_pkg::BtnColor, s1};
    end else if (bright_pend_q) begin
      e_first = {lrce_pkg::BtnBright, s2};
    end else begin
      e_first = {lrce_pkg::BtnRelease, lp_q[7:0]};
    end
    e_second = (color_pend_q && bright_pend_q) ? {lrce_pkg::BtnBright, s2}
                                               : {lrce_pkg::BtnRelease, s2};
    e_third  = {lrce_pkg::BtnRelease, s2};

    if (out_fire) begin
      if (burst_left_q != 4'd0) begin
        out_pkt_d    = {out_pkt_q[55:16], next_tail};
        out_last_d   = (burst_left_q == 4'd1);
        burst_left_d = burst_left_q - 4'd1;
        spare_d[0]   = spare_q[1];
      end else begin
        out_valid_d = 1'b0;
      end
    end

    if (in_fire) begin
      unique case (lrce_pkg::cmd_e'(cmd_i))
        lrce_pkg::CMD_CODE: begin
          if (32'(thr_q) > THROTTLE_LIMIT) begin
            rs = 8'd0;
          end else if (thr_q < lrce_pkg::ThrottleMax) begin
            thr_d = thr_q + 4'd1;
          end

          priority if (code_byte_i >= lrce_pkg::CodeShortFirst &&
                       code_byte_i <= lrce_pkg::CodeShortLast) begin
            known  = 1'b1;
            button = {5'd0, off} + lrce_pkg::ButtonOffset;
            if (!off[0]) group_d = {1'b0, off[2:1]} + 3'd1;
          end else if (code_byte_i >= lrce_pkg::CodeLongFirst &&
                       code_byte_i <= lrce_pkg::CodeLongLast) begin
            known   = 1'b1;
            button  = ({5'd0, off} + lrce_pkg::ButtonOffset) | lrce_pkg::LongPressBit;
            if (!off[0]) group_d = {1'b0, off[2:1]} + 3'd1;
            disco_d = lrce_pkg::DiscoOff;
          end else begin
            unique case (code_byte_i)
              lrce_pkg::CodeColor: begin
                known        = 1'b1;
                button       = lrce_pkg::BtnColor;
                color_d      = lrce_pkg::ColorBase - arg_byte_i;
                rs           = 8'd0;
                color_pend_d = 1'b1;
                disco_d      = lrce_pkg::DiscoOff;
              end
              lrce_pkg::CodeAllOn: begin
                known  = 1'b1;
                button = lrce_pkg::BtnAllOn;
              end
              lrce_pkg::CodeAllOff: begin
                known   = 1'b1;
                button  = lrce_pkg::BtnAllOff;
                group_d = 3'd0;
              end
              lrce_pkg::CodeLongOn: begin
                known   = 1'b1;
                button  = lrce_pkg::BtnLongOn;
                disco_d = lrce_pkg::DiscoOff;
              end
              lrce_pkg::CodeLongOff: begin
                known   = 1'b1;
                button  = lrce_pkg::BtnLongOff;
                group_d = 3'd0;
                disco_d = lrce_pkg::DiscoOff;
              end
              lrce_pkg::CodeSpeedUp: begin
                known  = 1'b1;
                button = lrce_pkg::BtnSpeedUp;
              end
              lrce_pkg::CodeSpeedDown: begin
                known  = 1'b1;
                button = lrce_pkg::BtnSpeedDown;
              end
              lrce_pkg::CodeDisco: begin
                known  = 1'b1;
                button = lrce_pkg::BtnDisco;
                if (disco_q == lrce_pkg::DiscoOff) begin
                  disco_d = 8'd0;
                end else if (disco_inc > lrce_pkg::DiscoLastStep) begin
                  disco_d = 8'd0;
                end else begin
                  disco_d = disco_inc;
                end
                color_pend_d  = 1'b0;
                bright_pend_d = 1'b0;
              end
              lrce_pkg::CodeBright: begin
                known         = 1'b1;
                button        = lrce_pkg::BtnBright;
                bright_d      = lrce_pkg::BrightBase - {arg_byte_i[4:0], 3'd0};
                bright_pend_d = 1'b1;
                rs            = 8'd0;
              end
              default: begin
                known = 1'b0;
              end
            endcase
          end

          if (known) begin
            seq_d = seq_q + 8'd1;
            if (disco_d != lrce_pkg::DiscoOff) begin
              b0 = lrce_pkg::Byte0Plain | disco_d;
            end else if (button >= lrce_pkg::BtnBright) begin
              b0 = lrce_pkg::Byte0Plain;
            end else begin
              b0 = lrce_pkg::Byte0Button;
            end
            lp_d = {b0, remote_address_q, color_d,
                    (bright_d & lrce_pkg::BrightMask) | {5'd0, group_d}, button, seq_d};
            if (!silent_q) begin
              out_valid_d   = 1'b1;
              out_pkt_d     = lp_d;
              out_rs_d      = rs;
              out_dl_d      = resend_delay_q;
              out_last_d    = 1'b1;
              burst_left_d  = 4'd0;
              burst_assoc_d = 1'b0;
            end
          end
        end

        lrce_pkg::CMD_IDLE: begin
          if (thr_q != 4'd0) thr_d = thr_q - 4'd1;
          seq_d         = s2;
          color_pend_d  = 1'b0;
          bright_pend_d = 1'b0;
          lp_d = {lp_q[55:48], remote_address_q, lp_q[31:16], lrce_pkg::BtnRelease,
                  (color_pend_q || bright_pend_q) ? s2 : lp_q[7:0]};
          if (!silent_q && (n_idle != 2'd0)) begin
            out_valid_d   = 1'b1;
            out_pkt_d     = {lp_q[55:48], remote_address_q, lp_q[31:16], e_first};
            out_rs_d      = default_resends_q;
            out_dl_d      = resend_delay_q;
            out_last_d    = (n_idle == 2'd1);
            burst_left_d  = {2'd0, n_idle - 2'd1};
            burst_assoc_d = 1'b0;
            spare_d[0]    = e_second;
            spare_d[1]    = e_third;
          end
        end

        lrce_pkg::CMD_ASSOC: begin
          if (!silent_q) begin
            out_valid_d   = 1'b1;
            out_pkt_d     = {lrce_pkg::Byte0Plain, assoc_addr_hi_i, assoc_addr_lo_i, 8'h00,
                             lrce_pkg::Byte0Button | {5'd0, agrp}, abtn, 8'd1};
            out_rs_d      = lrce_pkg::AssocResends;
            out_dl_d      = 20'd0;
            out_last_d    = 1'b0;
            burst_left_d  = lrce_pkg::AssocPackets - 4'd1;
            burst_assoc_d = 1'b1;
          end
        end

        lrce_pkg::CMD_RAW: begin
          if (!silent_q) begin
            out_valid_d   = 1'b1;
            out_pkt_d     = raw_packet_i;
            out_rs_d      = 8'd0;
            out_dl_d      = 20'd0;
            out_last_d    = 1'b1;
            burst_left_d  = 4'd0;
            burst_assoc_d = 1'b0;
          end
        end

        default: begin
          out_valid_d = out_valid_d;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remote_address_q  <= lrce_pkg::RemoteAddressReset;
      default_resends_q <= lrce_pkg::DefaultResendsReset;
      resend_delay_q    <= 20'd0;
      silent_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lrce_pkg::reg_e'(cfg_addr_i))
        lrce_pkg::REG_REMOTE_ADDRESS:  remote_address_q  <= cfg_wdata_i[15:0];
        lrce_pkg::REG_DEFAULT_RESENDS: default_resends_q <= cfg_wdata_i[7:0];
        lrce_pkg::REG_RESEND_DELAY:    resend_delay_q    <= cfg_wdata_i[19:0];
        lrce_pkg::REG_SILENT_MODE:     silent_q          <= cfg_wdata_i[0];
        default:                       silent_q          <= silent_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= 8'd0;
      color_q       <= 8'd0;
      bright_q      <= 8'd2;
      group_q       <= 3'd0;
      disco_q       <= lrce_pkg::DiscoOff;
      thr_q         <= 4'd0;
      color_pend_q  <= 1'b0;
      bright_pend_q <= 1'b0;
      lp_q          <= {lrce_pkg::Byte0Plain, 48'd0};
      out_valid_q   <= 1'b0;
      burst_left_q  <= 4'd0;
      burst_assoc_q <= 1'b0;
    end else begin
      seq_q         <= seq_d;
      color_q       <= color_d;
      bright_q      <= bright_d;
      group_q       <= group_d;
      disco_q       <= disco_d;
      thr_q         <= thr_d;
      color_pend_q  <= color_pend_d;
      bright_pend_q <= bright_pend_d;
      lp_q          <= lp_d;
      out_valid_q   <= out_valid_d;
      burst_left_q  <= burst_left_d;
      burst_assoc_q <= burst_assoc_d;
    end
  end

  // Result payload and the spare beats of an idle burst need no reset.
  always_ff @(posedge clk_i) begin
    out_pkt_q  <= out_pkt_d;
    out_rs_q   <= out_rs_d;
    out_dl_q   <= out_dl_d;
    out_last_q <= out_last_d;
    spare_q    <= spare_d;
  end

  assign out_valid_o    = out_valid_q;
  assign packet_bytes_o = out_pkt_q;
  assign resend_count_o = out_rs_q;
  assign resend_delay_o = out_dl_q;
  assign last_o         = out_last_q;

endmodule
